FILE: hdl/record_slot_allocator_assert.svh
// Assertion macros for the record slot allocator.
// Included by the top level; needs nothing else.
`ifndef RECORD_SLOT_ALLOCATOR_ASSERT_SVH
`define RECORD_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rsa_pkg.sv
// Shared types, codes and helpers for the record slot allocator.
// No dependencies.
`default_nettype none

package rsa_pkg;

    localparam int SLOTS   = 1024;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int HW_W    = SLOT_W + 1;
    localparam int ROW_W   = 32;
    localparam int ROWS    = SLOTS / ROW_W;
    localparam int ROW_AW  = $clog2(ROWS);
    localparam int COL_AW  = $clog2(ROW_W);
    localparam int LIM_W   = 11;
    localparam int LEN_W   = 13;
    localparam int CMP_W   = 13;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 3;

    localparam logic [ACT_W-1:0] ACT_PUT    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELETED = 3'd2;
    localparam logic [STAT_W-1:0] ST_SIZE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

    localparam logic [LIM_W-1:0] LIMIT_RESET  = 11'd1024;
    localparam logic [LEN_W-1:0] RECLEN_RESET = 13'd256;

    localparam logic [0:0] CFG_SLOT_LIMIT = 1'b0;
    localparam logic [0:0] CFG_RECORD_LEN = 1'b1;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] row;
        logic [ROW_W-1:0]  data;
    } t_map_wr;

    // Lowest set bit within a bitmap row.
    function automatic logic [COL_AW-1:0] lowest_col(input logic [ROW_W-1:0] v);
        logic [COL_AW-1:0] idx;
        idx = '0;
        for (int k = ROW_W - 1; k >= 0; k--) begin
            if (v[k]) idx = COL_AW'(k);
        end
        return idx;
    endfunction

    // Lowest row whose summary bit is set.
    function automatic logic [ROW_AW-1:0] lowest_row(input logic [ROWS-1:0] v);
        logic [ROW_AW-1:0] idx;
        idx = '0;
        for (int k = ROWS - 1; k >= 0; k--) begin
            if (v[k]) idx = ROW_AW'(k);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rsa_cmp.sv
// Shared magnitude comparator used by the allocator sequencer.
// Depends on rsa_pkg.
`default_nettype none

module rsa_cmp (
    input  wire logic [rsa_pkg::CMP_W-1:0] i_a,
    input  wire logic [rsa_pkg::CMP_W-1:0] i_b,
    output rsa_pkg::t_cmp                  o_res
);
    import rsa_pkg::*;

    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

`default_nettype wire

FILE: hdl/rsa_map.sv
// Freed-slot bitmap: row memory, per-row valid bits and per-row summary.
// Depends on rsa_pkg.
`default_nettype none

module rsa_map (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [rsa_pkg::ROW_AW-1:0] i_rd_row,
    output logic [rsa_pkg::ROW_W-1:0]       o_rd_data,
    input  wire rsa_pkg::t_map_wr           i_wr,
    output logic [rsa_pkg::ROWS-1:0]        o_any
);
    import rsa_pkg::*;

    logic [ROW_W-1:0] r_mem [ROWS];
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [ROWS-1:0]  r_vld;
    logic [ROWS-1:0]  r_any;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.row] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    // rows never written read as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_any    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_row];
            end
            if (i_wr.en) begin
                r_vld[i_wr.row] <= 1'b1;
                r_any[i_wr.row] <= |i_wr.data;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;
    assign o_any     = r_any;

endmodule

`default_nettype wire

FILE: hdl/record_slot_allocator.sv
// Record slot allocator: an accepted request steps through S_LEN, S_RNG, S_LIM and S_FIN;
// S_FIN loads the result register once the output is free; no new request is taken
// until then; three passes of one shared comparator and the bitmap row read set the pace.
// Reset: synchronous, active low; clears control, mark and row valid bits at once,
// so there is no clearing pass and a request may be taken on the first cycle after reset.
`default_nettype none

module record_slot_allocator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // request channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [rsa_pkg::ACT_W-1:0]  i_action,
    input  wire logic [rsa_pkg::SLOT_W-1:0] i_slot_id,
    input  wire logic [rsa_pkg::LEN_W-1:0]  i_data_length,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [rsa_pkg::STAT_W-1:0]      o_status,
    output logic [rsa_pkg::SLOT_W-1:0]      o_assigned_slot,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic [0:0]                 i_cfg_index,
    input  wire logic [rsa_pkg::LEN_W-1:0]  i_cfg_data
);
    import rsa_pkg::*;

    // sequencer: S_LEN compares length and reads the bitmap row,
    // S_RNG checks the slot against the mark, S_LIM the mark against the limit,
    // S_FIN commits state and loads the result register.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_RNG  = 3'd2;
    localparam logic [2:0] S_LIM  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        r_state, n_state;

    // configuration registers
    logic [LIM_W-1:0]  r_slot_limit;
    logic [LEN_W-1:0]  r_record_length;

    // captured request
    logic [ACT_W-1:0]  r_action;
    logic [SLOT_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_len;

    // high-water mark: never passes SLOTS
    logic [HW_W-1:0]   r_high_water, n_high_water;

    // comparator results gathered over the passes
    logic              r_len_gt, r_len_eq, r_in_range, r_hw_at_lim;
    logic              r_found;
    logic [ROW_AW-1:0] r_row;

    // result register
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [SLOT_W-1:0] r_assigned, n_assigned;

    // shared comparator
    logic [CMP_W-1:0]  cmp_a, cmp_b;
    t_cmp              cmp_res;

    // bitmap
    logic              map_rd_en;
    logic [ROW_AW-1:0] map_rd_row;
    logic [ROW_W-1:0]  map_rd_data;
    logic [ROWS-1:0]   map_any;
    t_map_wr           map_wr;

    logic              accept;
    logic              out_free;
    logic              full;
    logic [COL_AW-1:0] free_col;
    logic              slot_freed;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // mark at or above the effective limit min(slot_limit, SLOTS)
    assign full       = r_hw_at_lim || (r_high_water >= HW_W'(SLOTS));
    assign free_col   = lowest_col(map_rd_data);
    assign slot_freed = map_rd_data[r_slot[COL_AW-1:0]];

    rsa_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    rsa_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (map_rd_en),
        .i_rd_row  (map_rd_row),
        .o_rd_data (map_rd_data),
        .i_wr      (map_wr),
        .o_any     (map_any)
    );

    // comparator operand steering
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        case (r_state)
            S_LEN: begin
                cmp_a = CMP_W'(r_len);
                cmp_b = CMP_W'(r_record_length);
            end
            S_RNG: begin
                cmp_a = CMP_W'(r_slot);
                cmp_b = CMP_W'(r_high_water);
            end
            S_LIM: begin
                cmp_a = CMP_W'(r_high_water);
                cmp_b = CMP_W'(r_slot_limit);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    // bitmap row read: lowest non-empty row for a put, else the slot's row
    assign map_rd_en  = (r_state == S_LEN);
    assign map_rd_row = (r_action == ACT_PUT) ? lowest_row(map_any)
                                              : r_slot[SLOT_W-1:COL_AW];

    // state sequencing, and commit logic for the final step
    always_comb begin
        n_state      = r_state;
        n_high_water = r_high_water;
        n_out_valid  = r_out_valid && i_stall;
        n_status     = r_status;
        n_assigned   = r_assigned;
        map_wr.en    = 1'b0;
        map_wr.row   = r_row;
        map_wr.data  = map_rd_data;

        case (r_state)
            S_IDLE: if (accept) n_state = S_LEN;
            S_LEN:  n_state = S_RNG;
            S_RNG:  n_state = S_LIM;
            S_LIM:  n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_assigned  = '0;
                    case (r_action)
                        ACT_PUT: begin
                            if (r_len_gt) begin
                                n_status = ST_SIZE;
                            end else if (r_found) begin
                                // reuse the lowest freed slot
                                n_assigned            = {r_row, free_col};
                                map_wr.en             = 1'b1;
                                map_wr.data[free_col] = 1'b0;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_assigned   = r_high_water[SLOT_W-1:0];
                                n_high_water = r_high_water + HW_W'(1);
                            end
                        end
                        ACT_DELETE: begin
                            if (!r_in_range) begin
                                n_status = ST_RANGE;
                            end else begin
                                map_wr.en                         = 1'b1;
                                map_wr.data[r_slot[COL_AW-1:0]]   = 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            if (!r_in_range)     n_status = ST_RANGE;
                            else if (slot_freed) n_status = ST_DELETED;
                        end
                        default: begin
                            // update: size, range, exact size, liveness
                            if (r_len_gt)        n_status = ST_SIZE;
                            else if (!r_in_range) n_status = ST_RANGE;
                            else if (!r_len_eq)  n_status = ST_SIZE;
                            else if (slot_freed) n_status = ST_DELETED;
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_high_water    <= '0;
            r_out_valid     <= 1'b0;
            r_slot_limit    <= LIMIT_RESET;
            r_record_length <= RECLEN_RESET;
        end else begin
            r_state      <= n_state;
            r_high_water <= n_high_water;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOT_LIMIT: r_slot_limit    <= i_cfg_data[LIM_W-1:0];
                    CFG_RECORD_LEN: r_record_length <= i_cfg_data;
                    default:        r_record_length <= r_record_length;
                endcase
            end
        end
    end

    // payload and per-pass flags
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_assigned <= n_assigned;
        if (accept) begin
            r_action <= i_action;
            r_slot   <= i_slot_id;
            r_len    <= i_data_length;
        end
        case (r_state)
            S_LEN: begin
                r_len_gt <= !cmp_res.lt && !cmp_res.eq;
                r_len_eq <= cmp_res.eq;
                r_found  <= |map_any;
                r_row    <= map_rd_row;
            end
            S_RNG: r_in_range  <= cmp_res.lt;
            S_LIM: r_hw_at_lim <= !cmp_res.lt;
            default: begin
                r_len_gt <= r_len_gt;
            end
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_assigned_slot = r_assigned;

    `include "record_slot_allocator_assert.svh"

    `RSA_ASSERT_NOW(a_hw_bound, i_clk, i_rst_n, 1'b1, r_high_water <= HW_W'(SLOTS), "mark past capacity")
    `RSA_ASSERT_NOW(a_fail_no_slot, i_clk, i_rst_n, o_valid && (o_status != ST_OK), o_assigned_slot == '0, "slot on failure")
    `RSA_ASSERT_NOW(a_ok_below_mark, i_clk, i_rst_n, o_valid && (o_status == ST_OK), HW_W'(o_assigned_slot) < r_high_water, "ok beyond mark")
    `RSA_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, r_state == S_LEN, "request not started")

endmodule

`default_nettype wire

FILE: tb/sv/record_slot_allocator_checker.sv
// Scoreboard for the record slot allocator: watches both channels and the register port.
// Predicts each request's status and slot from a private copy of mark, bitmap and registers.
// Depends on rsa_pkg for widths and codes.
module record_slot_allocator_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_stall,
    input  logic [rsa_pkg::ACT_W-1:0]  i_action,
    input  logic [rsa_pkg::SLOT_W-1:0] i_slot_id,
    input  logic [rsa_pkg::LEN_W-1:0]  i_data_length,
    input  logic                       i_res_valid,
    input  logic                       i_res_stall,
    input  logic [rsa_pkg::STAT_W-1:0] i_status,
    input  logic [rsa_pkg::SLOT_W-1:0] i_assigned_slot,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_index,
    input  logic [rsa_pkg::LEN_W-1:0]  i_cfg_data,
    output int                         o_failures,
    output int                         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import rsa_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
    } t_outcome;

    t_outcome expected_outcomes[$];
    t_outcome want;
    t_outcome fresh;

    logic [HW_W-1:0]  mark;
    logic [SLOTS-1:0] freed;
    logic [LIM_W-1:0] limit;
    logic [LEN_W-1:0] rec_len;
    int               failures = 0;

    task automatic log_failure(input string what);
        failures++;
        if (failures <= 10) $display("[%0t] allocator check: %s", $realtime, what);
    endtask

    // Applies one request to the shadow state and returns what the block must answer.
    task automatic resolve_request(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] sid,
                                   input logic [LEN_W-1:0] len, output t_outcome res);
        int cap;
        int lowest;
        res.status = ST_OK;
        res.slot   = '0;
        cap = (int'(limit) < SLOTS) ? int'(limit) : SLOTS;
        case (act)
            ACT_PUT: begin
                if (len > rec_len) begin
                    res.status = ST_SIZE;
                end else begin
                    lowest = -1;
                    for (int k = SLOTS - 1; k >= 0; k--) begin
                        if (freed[k]) lowest = k;
                    end
                    if (lowest >= 0) begin
                        freed[lowest] = 1'b0;
                        res.slot = SLOT_W'(lowest);
                    end else if (int'(mark) >= cap) begin
                        res.status = ST_FULL;
                    end else begin
                        res.slot = mark[SLOT_W-1:0];
                        mark = mark + 1'b1;
                    end
                end
            end
            ACT_DELETE: begin
                if (HW_W'(sid) >= mark) res.status = ST_RANGE;
                else freed[sid] = 1'b1;
            end
            ACT_QUERY: begin
                if (HW_W'(sid) >= mark) res.status = ST_RANGE;
                else if (freed[sid]) res.status = ST_DELETED;
            end
            default: begin
                if (len > rec_len) res.status = ST_SIZE;
                else if (HW_W'(sid) >= mark) res.status = ST_RANGE;
                else if (len != rec_len) res.status = ST_SIZE;
                else if (freed[sid]) res.status = ST_DELETED;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mark    = '0;
            freed   = '0;
            limit   = LIMIT_RESET;
            rec_len = RECLEN_RESET;
            expected_outcomes.delete();
        end else begin
            // results first: a request taken on this edge cannot answer on it
            if (i_res_valid && !i_res_stall) begin
                if (expected_outcomes.size() == 0) begin
                    log_failure($sformatf("result with nothing outstanding: status %0d slot %0d",
                                          i_status, i_assigned_slot));
                end else begin
                    want = expected_outcomes.pop_front();
                    if (i_status !== want.status || i_assigned_slot !== want.slot)
                        log_failure($sformatf("status %0d slot %0d, expected status %0d slot %0d",
                                              i_status, i_assigned_slot, want.status, want.slot));
                end
            end
            if (i_req_valid && !i_req_stall) begin
                resolve_request(i_action, i_slot_id, i_data_length, fresh);
                expected_outcomes.push_back(fresh);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SLOT_LIMIT) limit = i_cfg_data[LIM_W-1:0];
                else rec_len = i_cfg_data;
            end
        end
        o_failures    = failures;
        o_outstanding = expected_outcomes.size();
    end

endmodule

FILE: tb/sv/tb_record_slot_allocator.sv
// Top of the record slot allocator bench: clock, reset, request and register stimulus, verdict.
// Depends on rsa_pkg, record_slot_allocator and record_slot_allocator_checker.
module tb_record_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import rsa_pkg::*;

    localparam int CYCLE_LIMIT = 600000;  // far above the slowest legal run
    localparam int SETTLE      = 8;       // extra margin after the last result
    localparam int MAX_LEN     = 4096;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [ACT_W-1:0]   action = ACT_PUT;
    logic [SLOT_W-1:0]  slot_id = '0;
    logic [LEN_W-1:0]   data_length = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  assigned_slot;
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = CFG_SLOT_LIMIT;
    logic [LEN_W-1:0]   cfg_data = '0;

    int failures;
    int outstanding;
    int cycles = 0;

    // stimulus view of the current registers, only used to aim the random requests
    int cur_len = 256;
    int max_cap = 0;
    int slot_span = 2;

    // receiver stall runs
    int   stall_run = 0;
    logic stall_level = 1'b0;
    int   stall_pick;

    // random phases: limit, record length, number of requests.
    // Limits go up and down so that the mark ends up above some of them.
    int phase_limit[7] = '{0, 6, 3, 20, 2047, 1024, 48};
    int phase_len[7]   = '{0, 37, 1, 4096, 256, 4095, 12};
    int phase_reqs[7]  = '{60, 150, 100, 200, 200, 200, 150};

    record_slot_allocator u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_action        (action),
        .i_slot_id       (slot_id),
        .i_data_length   (data_length),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_status        (status),
        .o_assigned_slot (assigned_slot),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    record_slot_allocator_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_action        (action),
        .i_slot_id       (slot_id),
        .i_data_length   (data_length),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_status        (status),
        .i_assigned_slot (assigned_slot),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_failures      (failures),
        .o_outstanding   (outstanding)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side back-pressure: mostly short stalls, a few long ones, and
    // long clear stretches so the block also runs flat out.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            stall_run = 0;
        end else begin
            if (stall_run == 0) begin
                stall_pick = $urandom_range(0, 99);
                if (stall_pick < 45) begin
                    stall_level = 1'b0;
                    stall_run = $urandom_range(1, 6);
                end else if (stall_pick < 55) begin
                    stall_level = 1'b0;
                    stall_run = $urandom_range(30, 120);
                end else if (stall_pick < 92) begin
                    stall_level = 1'b1;
                    stall_run = $urandom_range(1, 3);
                end else begin
                    stall_level = 1'b1;
                    stall_run = $urandom_range(10, 40);
                end
            end
            res_stall <= stall_level;
            stall_run--;
        end
    end

    // Idle cycles between requests; the short gaps land at every point of the block's turn.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 80) return $urandom_range(1, 4);
        if (p < 96) return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    // Presents one request and holds it until taken. Valid stays high when no
    // gap follows, so back-to-back requests never drop it.
    task automatic send_request(input logic [ACT_W-1:0] act, input int sid, input int len,
                                input int gap);
        req_valid   <= 1'b1;
        action      <= act;
        slot_id     <= SLOT_W'(sid);
        data_length <= LEN_W'(len);
        @(posedge clk);
        while (req_stall) @(posedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every request has been answered, then lets the pipeline settle.
    // Sampled on the falling edge so the checker's count is already up to date.
    task automatic drain();
        req_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Idle the block, then write both registers on consecutive edges.
    task automatic set_phase(input int lim, input int len);
        int cap;
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SLOT_LIMIT;
        cfg_data  <= LEN_W'(lim);
        @(posedge clk);
        cfg_index <= CFG_RECORD_LEN;
        cfg_data  <= LEN_W'(len);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_len = len;
        cap = (lim < SLOTS) ? lim : SLOTS;
        if (cap > max_cap) max_cap = cap;
        // the mark never passes the largest limit seen, so aim just beyond it
        slot_span = (max_cap + 2 < SLOTS) ? max_cap + 2 : SLOTS - 1;
    endtask

    // Random mix of put/delete/query/update, slots mostly near the live range
    // and lengths mostly at or around the record length.
    task automatic run_random(input int count);
        int p;
        int sid;
        int len;
        int gap;
        logic [ACT_W-1:0] act;
        logic burst;
        burst = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 0) burst = ($urandom_range(0, 3) == 0);
            p = $urandom_range(0, 99);
            if (p < 35) act = ACT_PUT;
            else if (p < 60) act = ACT_DELETE;
            else if (p < 80) act = ACT_QUERY;
            else act = ACT_UPDATE;
            if ($urandom_range(0, 99) < 85) sid = $urandom_range(0, slot_span);
            else sid = $urandom_range(0, SLOTS - 1);
            p = $urandom_range(0, 99);
            if (p < 50) len = cur_len;
            else if (p < 70) len = $urandom_range(0, cur_len);
            else if (p < 85 && cur_len < MAX_LEN) len = $urandom_range(cur_len + 1, MAX_LEN);
            else len = $urandom_range(0, MAX_LEN);
            gap = burst ? 0 : pick_gap();
            send_request(act, sid, len, gap);
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: two slots, longest record length.
        set_phase(2, MAX_LEN);
        send_request(ACT_QUERY,  0,    0,       pick_gap());  // empty store: out of range
        send_request(ACT_DELETE, 1023, 0,       pick_gap());  // top slot, out of range
        send_request(ACT_UPDATE, 0,    MAX_LEN, pick_gap());  // size fits, slot not yet issued
        send_request(ACT_PUT,    0,    MAX_LEN, pick_gap());  // slot 0 from the mark
        send_request(ACT_PUT,    0,    0,       pick_gap());  // slot 1 from the mark
        send_request(ACT_PUT,    0,    MAX_LEN, pick_gap());  // mark at limit: full
        send_request(ACT_UPDATE, 0,    MAX_LEN, pick_gap());  // live, exact size: ok
        send_request(ACT_UPDATE, 0,    100,     pick_gap());  // short length: bad size
        send_request(ACT_UPDATE, 5,    100,     pick_gap());  // range wins over inexact size
        send_request(ACT_QUERY,  1,    0,       pick_gap());  // live
        send_request(ACT_DELETE, 1,    0,       pick_gap());
        send_request(ACT_DELETE, 1,    0,       pick_gap());  // already freed: still ok
        send_request(ACT_QUERY,  1,    0,       pick_gap());  // deleted
        send_request(ACT_UPDATE, 1,    MAX_LEN, pick_gap());  // deleted
        send_request(ACT_DELETE, 0,    0,       pick_gap());
        send_request(ACT_PUT,    0,    1,       pick_gap());  // lowest freed first: slot 0
        send_request(ACT_PUT,    0,    1,       pick_gap());  // then slot 1
        send_request(ACT_PUT,    0,    1,       pick_gap());  // nothing freed: full
        send_request(ACT_QUERY,  1023, 0,       pick_gap());

        // Directed: zero record length.
        set_phase(2, 0);
        send_request(ACT_PUT,    0,    MAX_LEN, pick_gap());  // too long
        send_request(ACT_UPDATE, 1023, MAX_LEN, pick_gap());  // size checked before range
        send_request(ACT_UPDATE, 0,    0,       pick_gap());  // exact zero length: ok
        send_request(ACT_PUT,    0,    0,       pick_gap());  // full
        send_request(ACT_UPDATE, 0,    1,       pick_gap());  // too long

        // Random phases, each started from an idle block.
        for (int ph = 0; ph < 7; ph++) begin
            set_phase(phase_limit[ph], phase_len[ph]);
            run_random(phase_reqs[ph]);
        end

        drain();
        if (failures == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
